>>> rtl/txdr_pkg.sv
// Shared types, sizes and helpers for the transmit descriptor ring block.
// No dependencies; used by tx_descriptor_ring_admit.
package txdr_pkg;

  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned SLOT_W     = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned OUTS_W     = $clog2(RING_DEPTH + 1);
  localparam int unsigned LEN_W      = 12;
  localparam int unsigned CREDIT_W   = 13;

  localparam logic [CREDIT_W-1:0] CREDIT_MAX      = 13'd8191;
  localparam logic [CREDIT_W-1:0] BUF_SIZE_RESET  = 13'd4096;
  localparam logic [15:0]         TX_BASE_RESET   = 16'd4096;

  localparam logic [0:0] FUNC_SUBMIT = 1'b0;
  localparam logic [0:0] FUNC_DONE   = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_NOSPACE = 2'd2;

  // Register word indexes on the configuration port
  localparam logic [0:0] REG_BUF_SIZE = 1'b0;
  localparam logic [0:0] REG_TX_BASE  = 1'b1;

  typedef struct packed {
    logic [0:0]  func;
    logic [10:0] header_size;
    logic [10:0] data_size;
    logic [15:0] fifo_wr_ptr;
    logic [5:0]  slot;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [5:0]          desc_slot;
    logic [15:0]         frame_ptr;
    logic [LEN_W-1:0]    frame_len;
    logic [CREDIT_W-1:0] space_left;
    logic [6:0]          in_flight;
  } rsp_t;

  // Length rounded up to a 4-byte multiple
  function automatic logic [CREDIT_W-1:0] round4(input logic [LEN_W-1:0] v);
    logic [CREDIT_W-1:0] s;
    s = CREDIT_W'(v) + CREDIT_W'(3);
    return s & ~CREDIT_W'(3);
  endfunction

endpackage

>>> rtl/txdr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module txdr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/tx_descriptor_ring_admit.sv
// Transmit descriptor ring manager: reclaim, admission check and descriptor fill.
// Depends on txdr_pkg and txdr_ram (descriptor length and ready mark stores).
//
// Usage: after reset busy_o stays high while a clearing pass zeroes the ready marks,
// which live in a second RAM. Then raise start_i with a request on req_i while busy_o
// is low. A done request (func = 1) clears the ready mark of one slot and its result
// strobes on done_o in the next cycle. A submit request walks the ring from the oldest
// outstanding descriptor, one descriptor per cycle through the RAM read ports, until
// it meets one still marked ready or none is left outstanding; the cycle after the
// walk decides and, if admitted, fills. It reclaims 0 to 64 descriptors, and busy_o
// stays high until its result strobe. Each result is on rsp_o for the single cycle in
// which done_o is high and must be taken then.
// Writing tx_buffer_size also reloads the free credit; write configuration only while
// busy_o is low and no request is pending.
module tx_descriptor_ring_admit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  txdr_pkg::req_t   req_i,
  output logic             busy_o,
  output logic             done_o,
  output txdr_pkg::rsp_t   rsp_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned SW = txdr_pkg::SLOT_W;
  localparam int unsigned OW = txdr_pkg::OUTS_W;
  localparam int unsigned CW = txdr_pkg::CREDIT_W;
  localparam int unsigned LW = txdr_pkg::LEN_W;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_WALK} state_e;

  state_e                       state_q, state_d;
  logic [SW-1:0]                clr_q, clr_d;
  logic [SW-1:0]                next_q, next_d;
  logic [SW-1:0]                oldest_q, oldest_d;
  logic [OW-1:0]                outs_q, outs_d;
  logic [CW-1:0]                credit_q, credit_d;
  logic [CW-1:0]                buf_size_q, buf_size_d;
  logic [15:0]                  base_q, base_d;
  logic                         done_q, done_d;
  txdr_pkg::rsp_t               rsp_q, rsp_d;

  // request latch
  logic [LW-1:0]                len_q;
  logic [15:0]                  wptr_q;

  logic                         accept;
  logic                         cfg_wr;
  logic                         ram_we;
  logic [LW-1:0]                ram_rdata;
  logic                         rdy_we;
  logic [SW-1:0]                rdy_waddr;
  logic [0:0]                   rdy_wdata;
  logic [0:0]                   rdy_rdata;
  logic [CW-1:0]                need;
  logic [CW:0]                  credit_sum;
  logic                         can_reclaim;
  logic                         slot_ok;

  function automatic logic [SW-1:0] ring_next(input logic [SW-1:0] i);
    return (i == SW'(txdr_pkg::RING_DEPTH - 1)) ? '0 : i + SW'(1);
  endfunction

  assign accept  = start_i && !busy_o;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == txdr_pkg::REG_TX_BASE) ? {16'b0, base_q}
                                                         : {19'b0, buf_size_q};
  assign busy_o  = (state_q != ST_IDLE);
  assign done_o  = done_q;
  assign rsp_o   = rsp_q;

  assign need        = txdr_pkg::round4(len_q);
  assign credit_sum  = {1'b0, credit_q} + {1'b0, txdr_pkg::round4(ram_rdata)};
  assign can_reclaim = (outs_q != '0) && (rdy_rdata == 1'b0);
  assign slot_ok     = {3'b0, req_i.slot} < 9'(txdr_pkg::RING_DEPTH);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    next_d     = next_q;
    oldest_d   = oldest_q;
    outs_d     = outs_q;
    credit_d   = credit_q;
    buf_size_d = buf_size_q;
    base_d     = base_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    ram_we     = 1'b0;
    rdy_we     = 1'b0;
    rdy_waddr  = next_q;
    rdy_wdata  = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        rdy_we    = 1'b1;
        rdy_waddr = clr_q;
        clr_d     = ring_next(clr_q);
        if (clr_q == SW'(txdr_pkg::RING_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_i.func == txdr_pkg::FUNC_DONE) begin
            if (slot_ok) begin
              rdy_we    = 1'b1;
              rdy_waddr = SW'(req_i.slot);
              rdy_wdata = 1'b0;
            end
            rsp_d            = '0;
            rsp_d.status     = txdr_pkg::STATUS_OK;
            rsp_d.space_left = credit_q;
            rsp_d.in_flight  = 7'(outs_q);
            done_d           = 1'b1;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (can_reclaim) begin
          // ram_rdata holds the length of the oldest entry
          credit_d = credit_sum[CW] ? txdr_pkg::CREDIT_MAX
                   : ((credit_sum[CW-1:0] > txdr_pkg::CREDIT_MAX) ? txdr_pkg::CREDIT_MAX
                                                                  : credit_sum[CW-1:0]);
          oldest_d = ring_next(oldest_q);
          outs_d   = outs_q - OW'(1);
        end else begin
          rsp_d = '0;
          if (outs_q >= OW'(txdr_pkg::RING_DEPTH)) begin
            rsp_d.status = txdr_pkg::STATUS_FULL;
          end else if (credit_q < need) begin
            rsp_d.status = txdr_pkg::STATUS_NOSPACE;
          end else begin
            rsp_d.status     = txdr_pkg::STATUS_OK;
            rsp_d.desc_slot  = 6'(next_q);
            rsp_d.frame_ptr  = wptr_q + base_q;
            rsp_d.frame_len  = len_q;
            ram_we           = 1'b1;
            rdy_we           = 1'b1;
            rdy_waddr        = next_q;
            rdy_wdata        = 1'b1;
            next_d           = ring_next(next_q);
            outs_d           = outs_q + OW'(1);
            credit_d         = credit_q - need;
          end
          rsp_d.space_left = credit_d;
          rsp_d.in_flight  = 7'(outs_d);
          done_d           = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_wr) begin
      if (paddr[2] == txdr_pkg::REG_BUF_SIZE) begin
        buf_size_d = pwdata[CW-1:0];
        credit_d   = pwdata[CW-1:0];
      end else begin
        base_d = pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      next_q     <= '0;
      oldest_q   <= '0;
      outs_q     <= '0;
      credit_q   <= txdr_pkg::BUF_SIZE_RESET;
      buf_size_q <= txdr_pkg::BUF_SIZE_RESET;
      base_q     <= txdr_pkg::TX_BASE_RESET;
      done_q     <= 1'b0;
      rsp_q      <= '0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      next_q     <= next_d;
      oldest_q   <= oldest_d;
      outs_q     <= outs_d;
      credit_q   <= credit_d;
      buf_size_q <= buf_size_d;
      base_q     <= base_d;
      done_q     <= done_d;
      rsp_q      <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      len_q  <= LW'(req_i.header_size) + LW'(req_i.data_size);
      wptr_q <= req_i.fifo_wr_ptr;
    end
  end

  // Read addresses follow oldest_d so the data for oldest_q is ready each walk cycle.
  // Every write lands at an earlier edge than the next accept, whose read sees it.
  txdr_ram #(
    .WIDTH (LW),
    .DEPTH (txdr_pkg::RING_DEPTH)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (next_q),
    .wdata_i (len_q),
    .raddr_i (oldest_d),
    .rdata_o (ram_rdata)
  );

  txdr_ram #(
    .WIDTH (1),
    .DEPTH (txdr_pkg::RING_DEPTH)
  ) u_rdy_ram (
    .clk_i   (clk_i),
    .we_i    (rdy_we),
    .waddr_i (rdy_waddr),
    .wdata_i (rdy_wdata),
    .raddr_i (oldest_d),
    .rdata_o (rdy_rdata)
  );

  a_outs_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outs_q <= OW'(txdr_pkg::RING_DEPTH))
    else $error("outstanding count above ring depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (outs_q == '0) |-> (oldest_q == next_q))
    else $error("empty ring with oldest and next apart");

  a_accept_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_o || done_o))
    else $error("accepted request neither working nor answered");

  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != txdr_pkg::STATUS_OK) |->
      (rsp_o.desc_slot == '0 && rsp_o.frame_len == '0 && rsp_o.frame_ptr == '0))
    else $error("rejected submit carries descriptor fields");

endmodule
